// ===== hdl/slpe_pkg.sv =====
package slpe_pkg;

  // Field and timing constants
  localparam int unsigned PWM_MAX      = 1023;
  localparam int unsigned SINE_STEPS   = 1024;
  localparam int unsigned LVL_W        = 10;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned TMO_W        = 22;
  localparam int unsigned K_W          = $clog2(SINE_STEPS);
  localparam int unsigned QTR          = SINE_STEPS / 4;
  localparam int unsigned HALF         = SINE_STEPS / 2;
  localparam int unsigned J_W          = $clog2(QTR + 1);

  localparam int unsigned SLOW_PERIOD  = 2000;
  localparam int unsigned FAST_PERIOD  = 1600;
  localparam int unsigned SHORT_PERIOD = 800;
  localparam int unsigned FLASH_TOTAL  = 1500;
  localparam int unsigned SINCE_MAX    = 4194303;
  localparam int unsigned TMO_RESET    = 180000;
  localparam int unsigned PH_W         = 11;
  localparam int unsigned FLASH_W      = 11;

  // Breath sample k = floor(p * SINE_STEPS / SLOW_PERIOD), tracked as quotient + remainder
  localparam int unsigned IDLE_STEP_K  = SINE_STEPS / SLOW_PERIOD;
  localparam int unsigned IDLE_STEP_R  = SINE_STEPS % SLOW_PERIOD;
  localparam int unsigned IDLE_R_W     = $clog2(SLOW_PERIOD);

  // Marquee sample k = floor((3*sp + i*800) * SINE_STEPS / 2400)
  localparam int unsigned MQ_DEN       = 3 * SHORT_PERIOD;
  localparam int unsigned MQ_STEP_K    = (3 * SINE_STEPS) / MQ_DEN;
  localparam int unsigned MQ_STEP_R    = (3 * SINE_STEPS) % MQ_DEN;
  localparam int unsigned MQ_R_W       = $clog2(MQ_DEN);
  localparam int unsigned MQ_K1        = (SHORT_PERIOD * SINE_STEPS) / MQ_DEN;
  localparam int unsigned MQ_R1        = (SHORT_PERIOD * SINE_STEPS) % MQ_DEN;
  localparam int unsigned MQ_K2        = (2 * SHORT_PERIOD * SINE_STEPS) / MQ_DEN;
  localparam int unsigned MQ_R2        = (2 * SHORT_PERIOD * SINE_STEPS) % MQ_DEN;

  localparam logic [LVL_W-1:0] FULL_LEVEL = LVL_W'(PWM_MAX);

  // Request codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE    = 3'd0,
    MODE_THINK   = 3'd1,
    MODE_AUTH    = 3'd2,
    MODE_DONE    = 3'd3,
    MODE_ERROR   = 3'd4,
    MODE_CONFIG  = 3'd5,
    MODE_OFF     = 3'd6,
    MODE_UNKNOWN = 3'd7
  } mode_e;

  typedef struct packed {
    logic              func;
    logic [MODE_W-1:0] mode_code;
  } in_word_t;

  typedef struct packed {
    logic [LVL_W-1:0]  top_level;
    logic [LVL_W-1:0]  middle_level;
    logic [LVL_W-1:0]  bottom_level;
    logic [MODE_W-1:0] mode_now;
  } out_word_t;

  // Sample indices and blink state after the current tick
  typedef struct packed {
    logic [K_W-1:0]         k_idle;
    logic [2:0][K_W-1:0]    k_mq;
    logic                   err_on;
  } phase_t;

  typedef logic [LVL_W-1:0] lvl_tab_t [0:QTR];

  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // (1 + sin(2*pi*k/SINE_STEPS)) / 2 in Q30, odd polynomial, truncated products
  function automatic longint unsigned lift_q30(input longint unsigned k);
    longint unsigned turn;
    longint unsigned quad;
    longint unsigned f;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    turn = ((k % SINE_STEPS) << 32) / SINE_STEPS;
    quad = (turn >> 30) & 64'd3;
    f    = turn & (ONE_Q30 - 64'd1);
    if (quad[0]) f = ONE_Q30 - f;
    x2 = (f * f) >> 30;
    p  = 64'd172273;
    p  = 64'd5026995 - ((x2 * p) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    s  = (f * p) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    return (quad < 64'd2) ? ((ONE_Q30 + s) >> 1) : ((ONE_Q30 - s) >> 1);
  endfunction

  // Quarter-wave level table: upper or lower half-turn, plain or squared
  function automatic lvl_tab_t build_tab(input bit lower, input bit square);
    lvl_tab_t        t;
    longint unsigned b;
    for (int j = 0; j <= QTR; j++) begin
      b = lift_q30(lower ? longint'(HALF + j) : longint'(j));
      if (square) b = (b * b) >> 30;
      t[j] = LVL_W'((b * PWM_MAX) >> 30);
    end
    return t;
  endfunction

  localparam lvl_tab_t BR_UP = build_tab(1'b0, 1'b0);
  localparam lvl_tab_t BR_DN = build_tab(1'b1, 1'b0);
  localparam lvl_tab_t MQ_UP = build_tab(1'b0, 1'b1);
  localparam lvl_tab_t MQ_DN = build_tab(1'b1, 1'b1);

  // Fold a sample index onto the quarter table
  function automatic logic [J_W-1:0] fold_idx(input logic [K_W-1:0] k);
    logic [K_W-3:0] low;
    low = k[K_W-3:0];
    return k[K_W-2] ? J_W'(QTR - low) : J_W'(low);
  endfunction

  function automatic logic [LVL_W-1:0] breathe_lvl(input logic [K_W-1:0] k);
    return k[K_W-1] ? BR_DN[fold_idx(k)] : BR_UP[fold_idx(k)];
  endfunction

  function automatic logic [LVL_W-1:0] marquee_lvl(input logic [K_W-1:0] k);
    return k[K_W-1] ? MQ_DN[fold_idx(k)] : MQ_UP[fold_idx(k)];
  endfunction

endpackage

// ===== hdl/slpe_phase.sv =====
module slpe_phase (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  output slpe_pkg::phase_t phase_o
);
  import slpe_pkg::*;

  logic [PH_W-1:0]         slow_q, slow_d;
  logic [PH_W-1:0]         fast_q, fast_d;
  logic [K_W-1:0]          ki_q, ki_d;
  logic [IDLE_R_W-1:0]     ri_q, ri_d;
  logic [2:0][K_W-1:0]     mk_q, mk_d;
  logic [2:0][MQ_R_W-1:0]  mr_q, mr_d;
  logic [IDLE_R_W:0]       ri_sum;
  logic [MQ_R_W:0]         mr_sum;
  logic                    sp_zero;

  // Next phases and sample indices for one more millisecond
  always_comb begin
    slow_d = (slow_q == PH_W'(SLOW_PERIOD - 1)) ? '0 : slow_q + 1'b1;
    fast_d = (fast_q == PH_W'(FAST_PERIOD - 1)) ? '0 : fast_q + 1'b1;

    // idle breath index
    ri_sum = {1'b0, ri_q} + (IDLE_R_W + 1)'(IDLE_STEP_R);
    if (slow_d == '0) begin
      ki_d = '0;
      ri_d = '0;
    end else if (ri_sum >= (IDLE_R_W + 1)'(SLOW_PERIOD)) begin
      ki_d = ki_q + K_W'(IDLE_STEP_K) + 1'b1;
      ri_d = IDLE_R_W'(ri_sum - (IDLE_R_W + 1)'(SLOW_PERIOD));
    end else begin
      ki_d = ki_q + K_W'(IDLE_STEP_K);
      ri_d = ri_sum[IDLE_R_W-1:0];
    end

    // marquee indices restart with the short period
    sp_zero = (fast_d == '0) || (fast_d == PH_W'(SHORT_PERIOD));
    mr_sum  = '0;
    for (int i = 0; i < 3; i++) begin
      mr_sum = {1'b0, mr_q[i]} + (MQ_R_W + 1)'(MQ_STEP_R);
      if (mr_sum >= (MQ_R_W + 1)'(MQ_DEN)) begin
        mk_d[i] = mk_q[i] + K_W'(MQ_STEP_K) + 1'b1;
        mr_d[i] = MQ_R_W'(mr_sum - (MQ_R_W + 1)'(MQ_DEN));
      end else begin
        mk_d[i] = mk_q[i] + K_W'(MQ_STEP_K);
        mr_d[i] = mr_sum[MQ_R_W-1:0];
      end
    end
    if (sp_zero) begin
      mk_d[0] = '0;
      mr_d[0] = '0;
      mk_d[1] = K_W'(MQ_K1);
      mr_d[1] = MQ_R_W'(MQ_R1);
      mk_d[2] = K_W'(MQ_K2);
      mr_d[2] = MQ_R_W'(MQ_R2);
    end
  end

  // Counters advance on each tick; marquee LEDs start 120 degrees apart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q   <= '0;
      fast_q   <= '0;
      ki_q     <= '0;
      ri_q     <= '0;
      mk_q[0]  <= '0;
      mr_q[0]  <= '0;
      mk_q[1]  <= K_W'(MQ_K1);
      mr_q[1]  <= MQ_R_W'(MQ_R1);
      mk_q[2]  <= K_W'(MQ_K2);
      mr_q[2]  <= MQ_R_W'(MQ_R2);
    end else if (tick_i) begin
      slow_q <= slow_d;
      fast_q <= fast_d;
      ki_q   <= ki_d;
      ri_q   <= ri_d;
      mk_q   <= mk_d;
      mr_q   <= mr_d;
    end
  end

  assign phase_o.k_idle = ki_d;
  assign phase_o.k_mq   = mk_d;
  assign phase_o.err_on = (fast_d < PH_W'(FAST_PERIOD / 2));

endmodule

// ===== hdl/slpe_ctrl.sv =====
module slpe_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  slpe_pkg::in_word_t           word_i,
  input  slpe_pkg::phase_t             phase_i,
  input  logic                         cfg_we_i,
  input  logic [slpe_pkg::TMO_W-1:0]   cfg_wdata_i,
  output slpe_pkg::out_word_t          word_o
);
  import slpe_pkg::*;

  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [TMO_W-1:0]   since_q, since_d;
  logic [TMO_W-1:0]   tmo_q;
  logic               armed_q, armed_d;
  logic               run_q, run_d;
  logic [FLASH_W-1:0] el_q, el_d;

  logic [TMO_W-1:0]   since_inc;
  logic               fire;
  logic [MODE_W-1:0]  mode_t;
  logic               tk_run;
  logic [FLASH_W-1:0] tk_el;
  logic               flash_on;
  logic [LVL_W-1:0]   br_lvl;
  logic [LVL_W-1:0]   lv0, lv1, lv2;

  // Tick path: saturating silence count, timeout, flash sequence, levels
  always_comb begin
    since_inc = (since_q == TMO_W'(SINCE_MAX)) ? since_q : since_q + 1'b1;
    fire      = armed_q && (since_inc > tmo_q) &&
                (mode_q != MODE_OFF) && (mode_q != MODE_CONFIG);
    mode_t    = fire ? MODE_OFF : mode_q;

    tk_run = run_q;
    tk_el  = el_q;
    if (mode_t != MODE_DONE) begin
      tk_run = 1'b0;
    end else if (!run_q) begin
      tk_run = 1'b1;
      tk_el  = '0;
    end else if (el_q < FLASH_W'(FLASH_TOTAL)) begin
      tk_el = el_q + 1'b1;
    end
    // on during even 250 ms slots
    flash_on = tk_el inside {[0:249], [500:749], [1000:1249]};

    br_lvl = breathe_lvl((mode_t == MODE_IDLE) ? phase_i.k_idle : phase_i.k_mq[0]);

    case (mode_t)
      MODE_IDLE, MODE_CONFIG: begin
        lv0 = br_lvl;
        lv1 = br_lvl;
        lv2 = br_lvl;
      end
      MODE_THINK: begin
        lv0 = marquee_lvl(phase_i.k_mq[0]);
        lv1 = marquee_lvl(phase_i.k_mq[1]);
        lv2 = marquee_lvl(phase_i.k_mq[2]);
      end
      MODE_AUTH: begin
        lv0 = FULL_LEVEL;
        lv1 = FULL_LEVEL;
        lv2 = FULL_LEVEL;
      end
      MODE_ERROR: begin
        lv0 = phase_i.err_on ? FULL_LEVEL : '0;
        lv1 = lv0;
        lv2 = lv0;
      end
      MODE_DONE: begin
        lv0 = flash_on ? FULL_LEVEL : '0;
        lv1 = lv0;
        lv2 = lv0;
      end
      default: begin
        lv0 = '0;
        lv1 = '0;
        lv2 = '0;
      end
    endcase
  end

  // Next state for either request
  always_comb begin
    mode_d  = mode_q;
    since_d = since_q;
    armed_d = armed_q;
    run_d   = run_q;
    el_d    = el_q;
    if (word_i.func == FUNC_SET) begin
      if (word_i.mode_code != mode_q) begin
        mode_d  = word_i.mode_code;
        since_d = '0;
        armed_d = 1'b1;
        run_d   = 1'b0;
      end
    end else begin
      mode_d  = mode_t;
      since_d = fire ? '0 : since_inc;
      armed_d = armed_q | fire;
      run_d   = tk_run;
      el_d    = tk_el;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      since_q <= '0;
      armed_q <= 1'b0;
      run_q   <= 1'b0;
      el_q    <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      since_q <= since_d;
      armed_q <= armed_d;
      run_q   <= run_d;
      el_q    <= el_d;
    end
  end

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= TMO_W'(TMO_RESET);
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

  assign word_o.top_level    = lv0;
  assign word_o.middle_level = lv1;
  assign word_o.bottom_level = lv2;
  assign word_o.mode_now     = mode_t;

endmodule

// ===== hdl/status_led_pattern_engine_unit.sv =====
// Path: a tick word goes through the input register, then the result register; it waits
// in the input register while the result slot is full and not read.
// Throughput: one word per cycle but for such waits; phase and mode state update once per word.
// Mode-set words update state and give no result word.
// Reset (rst_ni low, asynchronous): idle mode, phase counters zero, timeout 180000,
// marquee LEDs at their 120-degree offsets, no word held in either register.
module status_led_pattern_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  slpe_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output slpe_pkg::out_word_t          out_word_o,
  input  logic                         cfg_we_i,
  input  logic [slpe_pkg::TMO_W-1:0]   cfg_wdata_i
);
  import slpe_pkg::*;

  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      adv;
  logic      tick;
  phase_t    phase;
  out_word_t res;

  // Input stage moves on when the result slot is free or the word makes no result
  assign adv        = s1_valid_q &&
                      ((s1_word_q.func == FUNC_SET) || !out_valid_q || out_ready_i);
  assign tick       = adv && (s1_word_q.func == FUNC_TICK);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  slpe_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .phase_o (phase)
  );

  slpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .word_i      (s1_word_q),
    .phase_i     (phase),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== tb/sv/status_led_pattern_engine_unit_tb.sv =====
`timescale 1ns / 100ps

module status_led_pattern_engine_unit_tb;
  import slpe_pkg::*;

  localparam int unsigned FLASH_SLOT_MS  = 250;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned DRAIN_CYCLES   = 10;

  // Sine polynomial coefficients, Q30
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned SIN_C1  = 64'd1686629713;
  localparam longint unsigned SIN_C3  = 64'd693598668;
  localparam longint unsigned SIN_C5  = 64'd85569306;
  localparam longint unsigned SIN_C7  = 64'd5026995;
  localparam longint unsigned SIN_C9  = 64'd172273;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_word_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_word_o;
  logic               cfg_we_i    = 1'b0;
  logic [TMO_W-1:0]   cfg_wdata_i = '0;

  status_led_pattern_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_word_t    words_to_send[$];
  out_word_t   led_frames_due[$];
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;

  // Shadow copy of the engine state
  mode_e            shadow_mode;
  int unsigned      slow_ms;
  int unsigned      fast_ms;
  int unsigned      quiet_ms;
  bit               quiet_armed;
  bit               flashing;
  int unsigned      flash_ms;
  logic [TMO_W-1:0] timeout_ms;

  out_word_t frame_now;
  bit        frame_made;

  task automatic flag_error(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // (1 + sin(2*pi*k/SINE_STEPS)) / 2 in Q30, truncated at every product
  function automatic longint unsigned sine_lift(input longint unsigned k);
    longint unsigned ang, quad, f, x2, p, s;
    ang  = ((k % SINE_STEPS) << 32) / SINE_STEPS;
    quad = (ang >> 30) & 64'd3;
    f    = ang & (Q30_ONE - 64'd1);
    if (quad[0]) f = Q30_ONE - f;
    x2 = (f * f) >> 30;
    p  = SIN_C9;
    p  = SIN_C7 - ((x2 * p) >> 30);
    p  = SIN_C5 - ((x2 * p) >> 30);
    p  = SIN_C3 - ((x2 * p) >> 30);
    p  = SIN_C1 - ((x2 * p) >> 30);
    s  = (f * p) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    return (quad < 64'd2) ? ((Q30_ONE + s) >> 1) : ((Q30_ONE - s) >> 1);
  endfunction

  function automatic logic [LVL_W-1:0] pwm_of(input longint unsigned q30);
    return LVL_W'((q30 * PWM_MAX) >> 30);
  endfunction

  function automatic void switch_mode(input mode_e m);
    shadow_mode = m;
    quiet_ms    = 0;
    quiet_armed = 1'b1;
    flashing    = 1'b0;
  endfunction

  function automatic void reset_shadow();
    shadow_mode = MODE_IDLE;
    slow_ms     = 0;
    fast_ms     = 0;
    quiet_ms    = 0;
    quiet_armed = 1'b0;
    flashing    = 1'b0;
    flash_ms    = 0;
    timeout_ms  = TMO_W'(TMO_RESET);
  endfunction

  // Advance the shadow engine by one word; a tick yields the LED frame
  function automatic void predict_led_frame(input in_word_t w, output out_word_t fr,
                                            output bit made);
    int unsigned     sp;
    longint unsigned k, b;
    logic [LVL_W-1:0] lv[3];
    fr   = '0;
    made = 1'b0;
    lv   = '{default: '0};
    if (w.func == FUNC_SET) begin
      if (w.mode_code != shadow_mode) switch_mode(mode_e'(w.mode_code));
      return;
    end
    slow_ms = (slow_ms + 1) % SLOW_PERIOD;
    fast_ms = (fast_ms + 1) % FAST_PERIOD;
    if (quiet_ms < SINCE_MAX) quiet_ms++;
    // silence forces off, except when already off or in config
    if (quiet_armed && quiet_ms > timeout_ms &&
        shadow_mode != MODE_OFF && shadow_mode != MODE_CONFIG)
      switch_mode(MODE_OFF);
    sp = fast_ms % SHORT_PERIOD;
    if (shadow_mode != MODE_DONE) flashing = 1'b0;
    case (shadow_mode)
      MODE_IDLE: begin
        lv[0] = pwm_of(sine_lift((longint'(slow_ms) * SINE_STEPS) / SLOW_PERIOD));
        lv[1] = lv[0];
        lv[2] = lv[0];
      end
      MODE_CONFIG: begin
        lv[0] = pwm_of(sine_lift((longint'(sp) * SINE_STEPS) / SHORT_PERIOD));
        lv[1] = lv[0];
        lv[2] = lv[0];
      end
      MODE_THINK: begin
        for (int i = 0; i < 3; i++) begin
          k = (longint'(3 * sp + i * SHORT_PERIOD) * SINE_STEPS) / (3 * SHORT_PERIOD);
          b = sine_lift(k);
          lv[i] = pwm_of((b * b) >> 30);
        end
      end
      MODE_AUTH: lv = '{default: LVL_W'(PWM_MAX)};
      MODE_ERROR: begin
        if (fast_ms < FAST_PERIOD / 2) lv = '{default: LVL_W'(PWM_MAX)};
      end
      MODE_DONE: begin
        if (!flashing) begin
          flashing = 1'b1;
          flash_ms = 0;
        end else if (flash_ms < FLASH_TOTAL) begin
          flash_ms++;
        end
        if (flash_ms < FLASH_TOTAL && ((flash_ms / FLASH_SLOT_MS) % 2) == 0)
          lv = '{default: LVL_W'(PWM_MAX)};
      end
      default: ;
    endcase
    fr.top_level    = lv[0];
    fr.middle_level = lv[1];
    fr.bottom_level = lv[2];
    fr.mode_now     = shadow_mode;
    made = 1'b1;
  endfunction

  // Driver: predict on acceptance, then offer the next pending word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_led_frame(in_word_i, frame_now, frame_made);
        if (frame_made) led_frames_due.push_back(frame_now);
      end
      if (!in_valid_i || in_ready_o) begin
        if (words_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_word_i  <= words_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted frame against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (led_frames_due.size() == 0) begin
          flag_error("unexpected frame, mode_now", out_word_o.mode_now, -1);
        end else begin
          frame_now = led_frames_due.pop_front();
          if (out_word_o.top_level !== frame_now.top_level)
            flag_error("top_level", out_word_o.top_level, frame_now.top_level);
          if (out_word_o.middle_level !== frame_now.middle_level)
            flag_error("middle_level", out_word_o.middle_level, frame_now.middle_level);
          if (out_word_o.bottom_level !== frame_now.bottom_level)
            flag_error("bottom_level", out_word_o.bottom_level, frame_now.bottom_level);
          if (out_word_o.mode_now !== frame_now.mode_now)
            flag_error("mode_now", out_word_o.mode_now, frame_now.mode_now);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_word(input logic f, input mode_e m);
    in_word_t w;
    w.func      = f;
    w.mode_code = m;
    words_to_send.push_back(w);
  endtask

  // Mostly a mode set followed by a run of ticks; some raw noise words
  task automatic queue_random(input int unsigned count);
    int unsigned made;
    int unsigned run;
    in_word_t    w;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 80) begin
        w.func      = FUNC_SET;
        w.mode_code = MODE_W'($urandom_range(7));
        words_to_send.push_back(w);
        made++;
        run = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 25);
        repeat (run) begin
          w.func      = FUNC_TICK;
          w.mode_code = MODE_W'($urandom_range(7));
          words_to_send.push_back(w);
          made++;
        end
      end else begin
        w = in_word_t'(4'($urandom_range(15)));
        words_to_send.push_back(w);
        made++;
      end
    end
  endtask

  // Wait until nothing is pending or in flight, then let the pipe drain
  task automatic wait_idle(input int unsigned extra);
    while (words_to_send.size() != 0 || in_valid_i || led_frames_due.size() != 0)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] v);
    wait_idle(SETTLE_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_ms = v;
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input logic [TMO_W-1:0] tmo, input int unsigned count);
    write_timeout(tmo);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    queue_random(count);
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every mode, repeated sets, unknown code, default timeout
    queue_word(FUNC_TICK, MODE_UNKNOWN);
    queue_word(FUNC_SET,  MODE_IDLE);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_THINK);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_AUTH);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_DONE);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_DONE);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_ERROR);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_CONFIG);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_TICK, MODE_UNKNOWN);
    queue_word(FUNC_SET,  MODE_OFF);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_UNKNOWN);
    queue_word(FUNC_SET,  MODE_UNKNOWN);
    queue_word(FUNC_TICK, MODE_IDLE);
    queue_word(FUNC_SET,  MODE_DONE);
    queue_word(FUNC_TICK, MODE_IDLE);

    run_phase(60, 0,  TMO_W'($urandom_range(300, 3000)), 110);
    run_phase(0,  60, TMO_W'(1), 110);
    run_phase(21, 21, TMO_W'(37), 110);
    run_phase(0,  0,  TMO_W'(SINCE_MAX), 110);

    // Hold done mode across the first flash slots
    queue_word(FUNC_SET, MODE_IDLE);
    queue_word(FUNC_SET, MODE_DONE);
    repeat (430) queue_word(FUNC_TICK, MODE_DONE);

    wait_idle(DRAIN_CYCLES);
    if (led_frames_due.size() != 0)
      flag_error("frames never delivered", 0, led_frames_due.size());
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
